@@ hw/rtl/ffa_pkg.sv @@
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared types, constants and state codes of the first-fit extent allocator.
// ----------------------------------------------------------------------------
package ffa_pkg;

    localparam int DEF_POOL_BYTES   = 1048576;
    localparam int DEF_FREE_EXTENTS = 32;
    localparam int DEF_MAX_LIVE     = 64;
    localparam int DEF_HEADER_BYTES = 16;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_NO_FIT  = 2'd1;
    localparam logic [1:0] STATUS_UNKNOWN = 2'd2;
    localparam logic [1:0] STATUS_FULL    = 2'd3;

    typedef struct packed {
        logic        kind;
        logic [20:0] req_size;
        logic [2:0]  align_log2;
        logic [19:0] address;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [19:0] result_address;
        logic [20:0] granted_bytes;
        logic [20:0] used_bytes;
        logic [6:0]  live_count;
    } rsp_t;

    typedef struct packed {
        logic [19:0] start;
        logic [20:0] length;
    } ext_t;

    typedef struct packed {
        logic        valid;
        logic [19:0] address;
        logic [20:0] length;
        logic [7:0]  adjust;
    } rec_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_CHECK,
        ST_REC_RD,
        ST_REC_EV,
        ST_EXT_RD,
        ST_EXT_EV,
        ST_MERGE,
        ST_RM_RD,
        ST_RM_WR,
        ST_INS_RD,
        ST_INS_WR,
        ST_ALLOC_WR,
        ST_FREE_WR,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic       init_wr;
        logic       req_load;
        logic       rec_step;
        logic       rec_hit;
        logic       ext_step;
        logic       ext_hit;
        logic       take;
        logic       upd_wr;
        logic       merge_wr;
        logic       rm_start;
        logic       rd_rm;
        logic       rm_wr;
        logic       rm_fin;
        logic       ins_start;
        logic       rd_ins;
        logic       ins_wr;
        logic       ins_put;
        logic       alloc_wr;
        logic       free_wr;
        logic       set_err;
        logic [1:0] err_code;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic kind;
        logic size_zero;
        logic live_full;
        logic init_last;
        logic rec_last;
        logic rec_free;
        logic rec_match;
        logic ext_end;
        logic fit;
        logic fit_rm;
        logic beyond;
        logic merge_prev;
        logic merge_next;
        logic ext_full;
        logic rm_done;
        logic ins_done;
        logic out_busy;
    } sts_t;

endpackage

@@ hw/rtl/ffa_ram.sv @@
// ----------------------------------------------------------------------------
// ffa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ffa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/ffa_ctrl.sv @@
// ----------------------------------------------------------------------------
// ffa_ctrl
// Sequencer: clearing pass, record scan, extent walk, table shifts, result.
// ----------------------------------------------------------------------------
module ffa_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  ffa_pkg::sts_t sts,
    output ffa_pkg::cmd_t cmd
);

    ffa_pkg::state_t state_reg;
    ffa_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ffa_pkg::ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ffa_pkg::ST_INIT:
                if (sts.init_last) state_next = ffa_pkg::ST_IDLE;
            ffa_pkg::ST_IDLE:
                if (req_valid) state_next = ffa_pkg::ST_CHECK;
            ffa_pkg::ST_CHECK:
                priority if (sts.kind == ffa_pkg::KIND_FREE) state_next = ffa_pkg::ST_REC_RD;
                else if (sts.size_zero || sts.live_full)     state_next = ffa_pkg::ST_DONE;
                else                                         state_next = ffa_pkg::ST_EXT_RD;
            ffa_pkg::ST_REC_RD:
                state_next = ffa_pkg::ST_REC_EV;
            ffa_pkg::ST_REC_EV:
                if (sts.kind == ffa_pkg::KIND_ALLOC)
                begin
                    state_next = sts.rec_free ? ffa_pkg::ST_ALLOC_WR : ffa_pkg::ST_REC_RD;
                end
                else
                begin
                    priority if (sts.rec_match) state_next = ffa_pkg::ST_EXT_RD;
                    else if (sts.rec_last)      state_next = ffa_pkg::ST_DONE;
                    else                        state_next = ffa_pkg::ST_REC_RD;
                end
            ffa_pkg::ST_EXT_RD:
                priority if (!sts.ext_end)                   state_next = ffa_pkg::ST_EXT_EV;
                else if (sts.kind == ffa_pkg::KIND_ALLOC)    state_next = ffa_pkg::ST_DONE;
                else                                         state_next = ffa_pkg::ST_MERGE;
            ffa_pkg::ST_EXT_EV:
                if (sts.kind == ffa_pkg::KIND_ALLOC)
                begin
                    priority if (!sts.fit) state_next = ffa_pkg::ST_EXT_RD;
                    else if (sts.fit_rm)   state_next = ffa_pkg::ST_RM_RD;
                    else                   state_next = ffa_pkg::ST_REC_RD;
                end
                else
                begin
                    state_next = sts.beyond ? ffa_pkg::ST_MERGE : ffa_pkg::ST_EXT_RD;
                end
            ffa_pkg::ST_MERGE:
                priority if (sts.merge_prev && sts.merge_next) state_next = ffa_pkg::ST_RM_RD;
                else if (sts.merge_prev || sts.merge_next)     state_next = ffa_pkg::ST_FREE_WR;
                else if (sts.ext_full)                         state_next = ffa_pkg::ST_DONE;
                else                                           state_next = ffa_pkg::ST_INS_RD;
            ffa_pkg::ST_RM_RD:
                priority if (!sts.rm_done)                state_next = ffa_pkg::ST_RM_WR;
                else if (sts.kind == ffa_pkg::KIND_ALLOC) state_next = ffa_pkg::ST_REC_RD;
                else                                      state_next = ffa_pkg::ST_FREE_WR;
            ffa_pkg::ST_RM_WR:
                state_next = ffa_pkg::ST_RM_RD;
            ffa_pkg::ST_INS_RD:
                state_next = sts.ins_done ? ffa_pkg::ST_FREE_WR : ffa_pkg::ST_INS_WR;
            ffa_pkg::ST_INS_WR:
                state_next = ffa_pkg::ST_INS_RD;
            ffa_pkg::ST_ALLOC_WR:
                state_next = ffa_pkg::ST_DONE;
            ffa_pkg::ST_FREE_WR:
                state_next = ffa_pkg::ST_DONE;
            ffa_pkg::ST_DONE:
                if (!sts.out_busy) state_next = ffa_pkg::ST_IDLE;
            default:
                state_next = ffa_pkg::ST_INIT;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd       = '0;
        req_stall = (state_reg != ffa_pkg::ST_IDLE);
        unique case (state_reg)
            ffa_pkg::ST_INIT:
                cmd.init_wr = 1'b1;
            ffa_pkg::ST_IDLE:
                cmd.req_load = req_valid;
            ffa_pkg::ST_CHECK:
                if (sts.kind == ffa_pkg::KIND_ALLOC)
                begin
                    priority if (sts.size_zero)
                    begin
                        cmd.set_err  = 1'b1;
                        cmd.err_code = ffa_pkg::STATUS_NO_FIT;
                    end
                    else if (sts.live_full)
                    begin
                        cmd.set_err  = 1'b1;
                        cmd.err_code = ffa_pkg::STATUS_FULL;
                    end
                    else
                    begin
                        cmd.set_err = 1'b0;
                    end
                end
            ffa_pkg::ST_REC_RD:
                cmd = '0;
            ffa_pkg::ST_REC_EV:
                if (sts.kind == ffa_pkg::KIND_ALLOC)
                begin
                    cmd.rec_hit  = sts.rec_free;
                    cmd.rec_step = !sts.rec_free;
                end
                else
                begin
                    priority if (sts.rec_match)
                    begin
                        cmd.rec_hit = 1'b1;
                    end
                    else if (sts.rec_last)
                    begin
                        cmd.set_err  = 1'b1;
                        cmd.err_code = ffa_pkg::STATUS_UNKNOWN;
                    end
                    else
                    begin
                        cmd.rec_step = 1'b1;
                    end
                end
            ffa_pkg::ST_EXT_RD:
                if (sts.ext_end && sts.kind == ffa_pkg::KIND_ALLOC)
                begin
                    cmd.set_err  = 1'b1;
                    cmd.err_code = ffa_pkg::STATUS_NO_FIT;
                end
            ffa_pkg::ST_EXT_EV:
                if (sts.kind == ffa_pkg::KIND_ALLOC)
                begin
                    cmd.ext_step = !sts.fit;
                    cmd.take     = sts.fit;
                    cmd.rm_start = sts.fit && sts.fit_rm;
                    cmd.upd_wr   = sts.fit && !sts.fit_rm;
                end
                else
                begin
                    cmd.ext_hit  = sts.beyond;
                    cmd.ext_step = !sts.beyond;
                end
            ffa_pkg::ST_MERGE:
                priority if (sts.merge_prev || sts.merge_next)
                begin
                    cmd.merge_wr = 1'b1;
                    cmd.rm_start = sts.merge_prev && sts.merge_next;
                end
                else if (sts.ext_full)
                begin
                    cmd.set_err  = 1'b1;
                    cmd.err_code = ffa_pkg::STATUS_FULL;
                end
                else
                begin
                    cmd.ins_start = 1'b1;
                end
            ffa_pkg::ST_RM_RD:
            begin
                cmd.rd_rm  = 1'b1;
                cmd.rm_fin = sts.rm_done;
            end
            ffa_pkg::ST_RM_WR:
                cmd.rm_wr = 1'b1;
            ffa_pkg::ST_INS_RD:
            begin
                cmd.rd_ins  = 1'b1;
                cmd.ins_put = sts.ins_done;
            end
            ffa_pkg::ST_INS_WR:
                cmd.ins_wr = 1'b1;
            ffa_pkg::ST_ALLOC_WR:
                cmd.alloc_wr = 1'b1;
            ffa_pkg::ST_FREE_WR:
                cmd.free_wr = 1'b1;
            ffa_pkg::ST_DONE:
                cmd.out_load = !sts.out_busy;
            default:
                cmd = '0;
        endcase
    end

    // only the idle state takes a request
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.req_load |-> state_reg == ffa_pkg::ST_IDLE)
        else $error("request loaded outside idle");
    a_done_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> state_reg == ffa_pkg::ST_IDLE)
        else $error("result load not followed by idle");
    a_one_ext_write: assert property (@(posedge clk) disable iff (!rst_n)
        $countones({cmd.upd_wr, cmd.merge_wr, cmd.rm_wr, cmd.ins_wr, cmd.ins_put}) <= 1)
        else $error("two extent writes in one cycle");

endmodule

@@ hw/rtl/ffa_datapath.sv @@
// ----------------------------------------------------------------------------
// ffa_datapath
// Extent and record RAMs, walk pointers, fit arithmetic, counters, result reg.
// ----------------------------------------------------------------------------
module ffa_datapath #(
    parameter int POOL_BYTES   = ffa_pkg::DEF_POOL_BYTES,
    parameter int FREE_EXTENTS = ffa_pkg::DEF_FREE_EXTENTS,
    parameter int MAX_LIVE     = ffa_pkg::DEF_MAX_LIVE,
    parameter int HEADER_BYTES = ffa_pkg::DEF_HEADER_BYTES
) (
    input  logic          clk,
    input  logic          rst_n,
    input  ffa_pkg::req_t req,
    input  ffa_pkg::cmd_t cmd,
    output ffa_pkg::sts_t sts,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output ffa_pkg::rsp_t rsp
);

    localparam int EXT_AW = $clog2(FREE_EXTENTS);
    localparam int CNT_W  = $clog2(FREE_EXTENTS + 1);
    localparam int REC_AW = (MAX_LIVE > 1) ? $clog2(MAX_LIVE) : 1;
    localparam int LIVE_W = $clog2(MAX_LIVE + 1);
    localparam int EXT_W  = $bits(ffa_pkg::ext_t);
    localparam int REC_W  = $bits(ffa_pkg::rec_t);

    function automatic logic [7:0] hdr_adjust(input logic [19:0] start,
                                              input logic [2:0]  lg,
                                              input logic [6:0]  hdr);
        logic [7:0] a;
        logic [7:0] mis;
        logic [7:0] adj0;
        logic [8:0] need;
        logic [8:0] up;
        logic [8:0] sum;
        a    = 8'd1 << lg;
        mis  = {1'b0, start[6:0]} & (a - 8'd1);
        adj0 = (mis != 8'd0) ? a - mis : 8'd0;
        need = 9'd0;
        up   = 9'd0;
        sum  = {1'b0, adj0};
        if ({1'b0, adj0} < {2'b00, hdr})
        begin
            need = {2'b00, hdr} - {1'b0, adj0};
            up   = (need + {1'b0, a} - 9'd1) & ~({1'b0, a} - 9'd1);
            sum  = {1'b0, adj0} + up;
        end
        return sum[7:0];
    endfunction

    ffa_pkg::req_t      req_reg;
    logic [REC_AW-1:0]  rptr_reg;
    logic [REC_AW-1:0]  slot_reg;
    logic [CNT_W-1:0]   eptr_reg;
    logic [CNT_W-1:0]   kptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [LIVE_W-1:0]  live_reg;
    logic [20:0]        bytes_reg;
    logic [19:0]        bstart_reg;
    logic [20:0]        blen_reg;
    ffa_pkg::ext_t      prev_reg;
    ffa_pkg::ext_t      cur_reg;
    logic               cur_hit_reg;
    logic [19:0]        s_reg;
    logic [7:0]         adj_reg;
    logic [20:0]        total_reg;
    logic [1:0]         res_status_reg;
    logic [19:0]        res_addr_reg;
    logic [20:0]        res_granted_reg;
    ffa_pkg::rsp_t      rsp_reg;
    logic               rsp_valid_reg;

    logic               ext_we;
    logic [EXT_AW-1:0]  ext_waddr;
    ffa_pkg::ext_t      ext_wdata;
    logic [EXT_AW-1:0]  ext_raddr;
    logic [EXT_W-1:0]   ext_rbits;
    ffa_pkg::ext_t      ext_rd;
    logic               rec_we;
    logic [REC_AW-1:0]  rec_waddr;
    ffa_pkg::rec_t      rec_wdata;
    logic [REC_W-1:0]   rec_rbits;
    ffa_pkg::rec_t      rec_rd;

    logic [7:0]         adj;
    logic [21:0]        total;
    logic [21:0]        remain;
    logic               fit_rm;
    logic [20:0]        bend;
    logic [CNT_W-1:0]   eptr_m1;
    logic [CNT_W-1:0]   kptr_p1;
    logic [CNT_W-1:0]   kptr_m1;
    logic               merge_prev;
    logic               merge_next;

    assign ext_rd = ffa_pkg::ext_t'(ext_rbits);
    assign rec_rd = ffa_pkg::rec_t'(rec_rbits);

    assign adj    = hdr_adjust(ext_rd.start, req_reg.align_log2, 7'(HEADER_BYTES));
    assign total  = {1'b0, req_reg.req_size} + {14'd0, adj};
    assign remain = {1'b0, ext_rd.length} - total;
    assign fit_rm = remain <= 22'(HEADER_BYTES);
    assign bend   = {1'b0, bstart_reg} + blen_reg;
    assign eptr_m1 = eptr_reg - 1'b1;
    assign kptr_p1 = kptr_reg + 1'b1;
    assign kptr_m1 = kptr_reg - 1'b1;

    assign merge_prev = (eptr_reg != '0) &&
                        (({1'b0, prev_reg.start} + prev_reg.length) == {1'b0, bstart_reg});
    assign merge_next = cur_hit_reg && ({1'b0, cur_reg.start} == bend);

    always_comb
    begin
        sts.kind       = req_reg.kind;
        sts.size_zero  = (req_reg.req_size == 21'd0);
        sts.live_full  = (live_reg >= LIVE_W'(MAX_LIVE));
        sts.init_last  = (rptr_reg == REC_AW'(MAX_LIVE - 1));
        sts.rec_last   = (rptr_reg == REC_AW'(MAX_LIVE - 1));
        sts.rec_free   = !rec_rd.valid;
        sts.rec_match  = rec_rd.valid && (rec_rd.address == req_reg.address);
        sts.ext_end    = (eptr_reg >= count_reg);
        sts.fit        = ({1'b0, ext_rd.length} >= total);
        sts.fit_rm     = fit_rm;
        sts.beyond     = ({1'b0, ext_rd.start} >= bend);
        sts.merge_prev = merge_prev;
        sts.merge_next = merge_next;
        sts.ext_full   = (count_reg >= CNT_W'(FREE_EXTENTS));
        sts.rm_done    = (kptr_p1 >= count_reg);
        sts.ins_done   = (kptr_reg == eptr_reg);
        sts.out_busy   = rsp_valid_reg && rsp_stall;
    end

    // extent RAM ports
    always_comb
    begin
        ext_we    = 1'b0;
        ext_waddr = eptr_reg[EXT_AW-1:0];
        ext_wdata = ext_rd;
        priority if (cmd.init_wr)
        begin
            ext_we    = (rptr_reg == '0);
            ext_waddr = '0;
            ext_wdata = '{start: 20'd0, length: 21'(POOL_BYTES)};
        end
        else if (cmd.upd_wr)
        begin
            ext_we    = 1'b1;
            ext_wdata = '{start: ext_rd.start + total[19:0],
                          length: ext_rd.length - total[20:0]};
        end
        else if (cmd.merge_wr)
        begin
            ext_we = 1'b1;
            if (merge_prev)
            begin
                ext_waddr = eptr_m1[EXT_AW-1:0];
                ext_wdata = '{start: prev_reg.start,
                              length: prev_reg.length + blen_reg +
                                      (merge_next ? cur_reg.length : 21'd0)};
            end
            else
            begin
                ext_wdata = '{start: bstart_reg, length: cur_reg.length + blen_reg};
            end
        end
        else if (cmd.rm_wr || cmd.ins_wr)
        begin
            ext_we    = 1'b1;
            ext_waddr = kptr_reg[EXT_AW-1:0];
        end
        else if (cmd.ins_put)
        begin
            ext_we    = 1'b1;
            ext_wdata = '{start: bstart_reg, length: blen_reg};
        end
        else
        begin
            ext_we = 1'b0;
        end
    end

    always_comb
    begin
        priority if (cmd.rd_rm) ext_raddr = kptr_p1[EXT_AW-1:0];
        else if (cmd.rd_ins)    ext_raddr = kptr_m1[EXT_AW-1:0];
        else                    ext_raddr = eptr_reg[EXT_AW-1:0];
    end

    // record RAM write port
    always_comb
    begin
        rec_we    = cmd.init_wr || cmd.alloc_wr || cmd.free_wr;
        rec_waddr = cmd.free_wr ? slot_reg : rptr_reg;
        rec_wdata = '0;
        if (cmd.alloc_wr)
        begin
            rec_wdata = '{valid: 1'b1, address: s_reg + {12'd0, adj_reg},
                          length: total_reg, adjust: adj_reg};
        end
    end

    ffa_ram #(.WIDTH(EXT_W), .DEPTH(FREE_EXTENTS), .AW(EXT_AW)) u_ext_ram (
        .clk   (clk),
        .we    (ext_we),
        .waddr (ext_waddr),
        .wdata (EXT_W'(ext_wdata)),
        .raddr (ext_raddr),
        .rdata (ext_rbits)
    );

    ffa_ram #(.WIDTH(REC_W), .DEPTH(MAX_LIVE), .AW(REC_AW)) u_rec_ram (
        .clk   (clk),
        .we    (rec_we),
        .waddr (rec_waddr),
        .wdata (REC_W'(rec_wdata)),
        .raddr (rptr_reg),
        .rdata (rec_rbits)
    );

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rptr_reg      <= '0;
            eptr_reg      <= '0;
            kptr_reg      <= '0;
            count_reg     <= CNT_W'(1);
            live_reg      <= '0;
            bytes_reg     <= '0;
            cur_hit_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.init_wr || cmd.rec_step)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            else if (cmd.req_load)
            begin
                rptr_reg <= '0;
            end

            if (cmd.req_load)
            begin
                eptr_reg    <= '0;
                cur_hit_reg <= 1'b0;
            end
            else if (cmd.ext_step)
            begin
                eptr_reg <= eptr_reg + 1'b1;
            end
            else if (cmd.ext_hit)
            begin
                cur_hit_reg <= 1'b1;
            end

            priority if (cmd.rm_start) kptr_reg <= eptr_reg;
            else if (cmd.ins_start)    kptr_reg <= count_reg;
            else if (cmd.rm_wr)        kptr_reg <= kptr_p1;
            else if (cmd.ins_wr)       kptr_reg <= kptr_m1;
            else                       kptr_reg <= kptr_reg;

            if (cmd.rm_fin)
            begin
                count_reg <= count_reg - 1'b1;
            end
            else if (cmd.ins_put)
            begin
                count_reg <= count_reg + 1'b1;
            end

            if (cmd.alloc_wr)
            begin
                live_reg  <= live_reg + 1'b1;
                bytes_reg <= bytes_reg + total_reg;
            end
            else if (cmd.free_wr)
            begin
                if (live_reg != '0)
                begin
                    live_reg <= live_reg - 1'b1;
                end
                bytes_reg <= (bytes_reg >= blen_reg) ? bytes_reg - blen_reg : 21'd0;
            end

            if (cmd.out_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.req_load)
        begin
            req_reg <= req;
        end
        if (cmd.rec_hit)
        begin
            slot_reg   <= rptr_reg;
            bstart_reg <= req_reg.address - {12'd0, rec_rd.adjust};
            blen_reg   <= rec_rd.length;
        end
        if (cmd.ext_step)
        begin
            prev_reg <= ext_rd;
        end
        if (cmd.ext_hit)
        begin
            cur_reg <= ext_rd;
        end
        if (cmd.take)
        begin
            s_reg     <= ext_rd.start;
            adj_reg   <= adj;
            total_reg <= fit_rm ? ext_rd.length : total[20:0];
        end
        priority if (cmd.set_err)
        begin
            res_status_reg  <= cmd.err_code;
            res_addr_reg    <= 20'd0;
            res_granted_reg <= 21'd0;
        end
        else if (cmd.alloc_wr)
        begin
            res_status_reg  <= ffa_pkg::STATUS_OK;
            res_addr_reg    <= s_reg + {12'd0, adj_reg};
            res_granted_reg <= total_reg;
        end
        else if (cmd.free_wr)
        begin
            res_status_reg  <= ffa_pkg::STATUS_OK;
            res_addr_reg    <= 20'd0;
            res_granted_reg <= blen_reg;
        end
        else
        begin
            res_status_reg <= res_status_reg;
        end
        if (cmd.out_load)
        begin
            rsp_reg <= '{status: res_status_reg, result_address: res_addr_reg,
                         granted_bytes: res_granted_reg, used_bytes: bytes_reg,
                         live_count: 7'(live_reg)};
        end
    end

    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(FREE_EXTENTS))
        else $error("extent count above table size");
    a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
        live_reg <= LIVE_W'(MAX_LIVE))
        else $error("live count above record table size");
    a_shift_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.rm_wr || cmd.ins_wr) |-> kptr_reg < CNT_W'(FREE_EXTENTS))
        else $error("shift write outside extent table");
    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ins_put |=> count_reg == $past(count_reg) + 1'b1)
        else $error("insert did not grow extent table");

endmodule

@@ hw/rtl/first_fit_extent_allocator.sv @@
// ----------------------------------------------------------------------------
// first_fit_extent_allocator
// First-fit pool allocator over an address-sorted free-extent table.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid / req_stall / req) carries one transaction per
//   allocate or free request; rsp channel (rsp_valid / rsp_stall / rsp)
//   returns exactly one result transaction for each request, in order.
//   A transaction moves on a rising edge with valid high and stall low.
// Sequence, one request at a time:
//   allocate walks the extents until the fit, shifts entries when an extent
//   is used up, then scans the records to find a free slot; free scans the
//   records for the address, walks the extents, and shifts entries on insert
//   or double merge. Each table entry is handled in a read state that
//   addresses the RAM, then an evaluate state on the registered read data.
// Reset: the free-extent table holds one extent covering the pool and the
//   record RAM gets a clearing pass over every record, req_stall held high.
// Back-pressure: results sit in an output register. While rsp_stall holds a
//   result, the next request is still taken and processed; its result waits
//   in the datapath while the sequencer waits for the output register to free up.
// ----------------------------------------------------------------------------
module first_fit_extent_allocator #(
    parameter int POOL_BYTES   = ffa_pkg::DEF_POOL_BYTES,
    parameter int FREE_EXTENTS = ffa_pkg::DEF_FREE_EXTENTS,
    parameter int MAX_LIVE     = ffa_pkg::DEF_MAX_LIVE,
    parameter int HEADER_BYTES = ffa_pkg::DEF_HEADER_BYTES
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  ffa_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output ffa_pkg::rsp_t rsp
);

    // command / status pair between sequencer and datapath
    ffa_pkg::cmd_t cmd;
    ffa_pkg::sts_t sts;

    ffa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    ffa_datapath #(
        .POOL_BYTES   (POOL_BYTES),
        .FREE_EXTENTS (FREE_EXTENTS),
        .MAX_LIVE     (MAX_LIVE),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule
